// File: rtl/core/isort_pkg.sv
package isort_pkg;

  // Capacity of the sorting chain, one cell per stored value.
  localparam int MAX_ITEMS = 32;
  localparam int DATA_W    = 32;

  // Input request: one value to be sorted.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_in;
  } in_req_t;

  // Output request: one sorted value.
  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     overflow;
  } out_req_t;

  // Broadcast control shared by every cell of the chain.
  typedef struct packed {
    logic                     ins;
    logic                     pop;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

  // Controller states.
  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

endpackage

// File: rtl/core/insertion_sorter.sv
// Channel  | Ports                          | Direction
// -------- | ------------------------------ | ---------
// input    | in_valid, in_stall, in_req     | into block
// result   | out_valid, out_stall, out_req  | out of block
//
// While loading, one request is taken every cycle; each is inserted into the
// cell chain by a broadcast compare and a one-place shift, or dropped if full.
// A request with last_in set starts the drain: one stored value per cycle
// leaves cell 0 while the output is not stalled.
// Input is stalled during the drain; an output stall holds the chain in place.
// Reset empties the chain at once and clears the overflow flag.
module insertion_sorter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  isort_pkg::in_req_t  in_req,
  output logic                out_valid,
  input  logic                out_stall,
  output isort_pkg::out_req_t out_req
);
  import isort_pkg::*;

  state_t     state_r, state_nxt;
  cell_ctrl_t ctrl;
  logic       dropped_r, dropped_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_req_t   out_req_r;
  logic       out_ready;
  logic       full;
  logic       in_acc;

  logic signed [DATA_W-1:0] cell_data  [MAX_ITEMS];
  logic                     cell_valid [MAX_ITEMS];
  logic                     cell_gt    [MAX_ITEMS];

  assign full      = cell_valid[MAX_ITEMS-1];
  assign out_ready = !out_valid_r || !out_stall;
  assign in_acc    = in_valid && !in_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid && in_req.last_in) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!cell_valid[0]) begin
          state_nxt = ST_LOAD;
        end else if (out_ready && !cell_valid[1]) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_stall   = 1'b0;
    ctrl.ins   = 1'b0;
    ctrl.pop   = 1'b0;
    ctrl.value = in_req.value;
    unique case (state_r)
      ST_LOAD: begin
        ctrl.ins = in_valid && !full;
      end
      ST_DRAIN: begin
        in_stall = 1'b1;
        ctrl.pop = out_ready && cell_valid[0];
      end
      default: in_stall = 1'b1;
    endcase
  end

  // Sticky drop flag for the current run.
  always_comb begin
    dropped_nxt = dropped_r;
    if (in_acc && full) begin
      dropped_nxt = 1'b1;
    end else if (state_r == ST_DRAIN && state_nxt == ST_LOAD) begin
      dropped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  // The chain of cells.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev_data, next_data;
    logic                     prev_valid, prev_gt, next_valid;

    if (i == 0) begin : g_first
      assign prev_data  = '0;
      assign prev_valid = 1'b1;
      assign prev_gt    = 1'b0;
    end else begin : g_mid
      assign prev_data  = cell_data[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_gt    = cell_gt[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_end
      assign next_data  = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_data  = cell_data[i+1];
      assign next_valid = cell_valid[i+1];
    end

    isort_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prev_data  (prev_data),
      .prev_valid (prev_valid),
      .prev_gt    (prev_gt),
      .next_data  (next_data),
      .next_valid (next_valid),
      .data       (cell_data[i]),
      .valid      (cell_valid[i]),
      .gt         (cell_gt[i])
    );
  end

  // Output register: loaded from cell 0 on every pop.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      out_req_r.sorted_value <= cell_data[0];
      out_req_r.last_out     <= !cell_valid[1];
      out_req_r.overflow     <= dropped_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

endmodule

// File: rtl/core/isort_cell.sv
module isort_cell (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  isort_pkg::cell_ctrl_t                ctrl,
  input  logic signed [isort_pkg::DATA_W-1:0]  prev_data,
  input  logic                                 prev_valid,
  input  logic                                 prev_gt,
  input  logic signed [isort_pkg::DATA_W-1:0]  next_data,
  input  logic                                 next_valid,
  output logic signed [isort_pkg::DATA_W-1:0]  data,
  output logic                                 valid,
  output logic                                 gt
);
  import isort_pkg::*;

  logic signed [DATA_W-1:0] data_r, data_nxt;
  logic                     valid_r, valid_nxt;
  logic                     load;

  // Strictly greater entries move up, so equal keys keep arrival order.
  assign gt   = valid_r && (data_r > ctrl.value);
  assign load = gt || (!valid_r && prev_valid);

  // Insert takes the lower neighbor or the new value; pop shifts toward cell 0.
  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (ctrl.pop) begin
      data_nxt  = next_data;
      valid_nxt = next_valid;
    end else if (ctrl.ins && load) begin
      data_nxt  = prev_gt ? prev_data : ctrl.value;
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign data  = data_r;
  assign valid = valid_r;

endmodule

// File: rtl/core/isort_checker.sv
module isort_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input isort_pkg::in_req_t  in_req,
  input logic                out_valid,
  input logic                out_stall,
  input isort_pkg::out_req_t out_req
);
  import isort_pkg::*;

  logic out_acc;
  assign out_acc = out_valid && !out_stall;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_req))
    else $error("stalled result changed");

  // Input is only stalled after a request that closed a run.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid && !in_stall && in_req.last_in))
    else $error("input stalled without a closing request");

  // While a result that is not the last of its run is offered, more of the run
  // are still in the chain, so input is stalled.
  a_drain_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_req.last_out |-> in_stall)
    else $error("input taken in the middle of a drain");

  // Results of one run come out in ascending order.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_req.last_out ##1 out_valid |->
      out_req.sorted_value >= $past(out_req.sorted_value))
    else $error("results out of order");

  // The overflow flag is the same on every result of a run.
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_req.last_out ##1 out_valid |->
      out_req.overflow == $past(out_req.overflow))
    else $error("overflow flag changed within a run");

endmodule

bind insertion_sorter isort_checker u_isort_checker (.*);

// File: tb/tb_insertion_sorter.sv
`timescale 1ns / 100ps

module tb_insertion_sorter;
  import isort_pkg::*;

  localparam int HOLD_CYCLES   = 200;
  localparam int RANDOM_ITEMS  = 85;
  localparam int TAIL_CYCLES   = 2 * MAX_ITEMS + 8;

  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  // Kinds of value that a random run is drawn from.
  typedef enum int {
    MIX_FULL,
    MIX_NARROW,
    MIX_EDGE
  } value_mix_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_req;

  // Sorted values still owed by the block, oldest first.
  out_req_t    sorted_expect[$];
  int          mismatch_count = 0;
  int          items_sent = 0;

  // Shadow of the block's sorted store.
  logic signed [DATA_W-1:0] shadow_store[MAX_ITEMS];
  int          shadow_fill = 0;
  bit          shadow_dropped = 1'b0;

  // Sender burst and receiver stall controls.
  int          gap_max = 0;
  int          burst_left = 0;
  int          stall_max = 0;
  int          go_max = 4;
  int          stall_run_left = 0;
  int          hold_left = 0;
  bit          hold_output = 1'b0;

  insertion_sorter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Insert one accepted value into the shadow store; a last request releases
  // the whole store in ascending order.
  task automatic insert_and_release(input in_req_t req);
    logic signed [DATA_W-1:0] v;
    int pos;
    out_req_t res;
    v = req.value;
    if (shadow_fill >= MAX_ITEMS) begin
      shadow_dropped = 1'b1;
    end else begin
      pos = shadow_fill;
      while (pos > 0 && shadow_store[pos-1] > v) begin
        shadow_store[pos] = shadow_store[pos-1];
        pos--;
      end
      shadow_store[pos] = v;
      shadow_fill++;
    end
    if (req.last_in) begin
      for (int k = 0; k < shadow_fill; k++) begin
        res.sorted_value = shadow_store[k];
        res.last_out     = (k == shadow_fill - 1);
        res.overflow     = shadow_dropped;
        sorted_expect.push_back(res);
      end
      shadow_fill    = 0;
      shadow_dropped = 1'b0;
    end
  endtask

  // Watch both channels; all values read here are those before the edge.
  always @(posedge clk) begin : monitor
    out_req_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        insert_and_release(in_req);
      end
      if (out_valid && !out_stall) begin
        if (sorted_expect.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual value %0d last %0b ovf %0b",
                   $time, out_req.sorted_value, out_req.last_out, out_req.overflow);
          mismatch_count++;
        end else begin
          want = sorted_expect.pop_front();
          if (out_req.sorted_value !== want.sorted_value) begin
            $display("%0t: sorted_value expected %0d, actual %0d",
                     $time, want.sorted_value, out_req.sorted_value);
            mismatch_count++;
          end
          if (out_req.last_out !== want.last_out) begin
            $display("%0t: last_out expected %0b, actual %0b",
                     $time, want.last_out, out_req.last_out);
            mismatch_count++;
          end
          if (out_req.overflow !== want.overflow) begin
            $display("%0t: overflow expected %0b, actual %0b",
                     $time, want.overflow, out_req.overflow);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Receiver: alternating stall and go runs, or one long hold when requested.
  always @(posedge clk) begin : receiver
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_output) begin
      hold_output = 1'b0;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (stall_run_left != 0) begin
      stall_run_left--;
    end else if (out_stall || stall_max == 0) begin
      out_stall <= 1'b0;
      stall_run_left = $urandom_range(go_max, 0);
    end else begin
      out_stall <= 1'b1;
      stall_run_left = $urandom_range(stall_max - 1, 0);
    end
  end

  // Offer one request and hold it until it is taken; gaps fall between bursts.
  task automatic send_item(input logic signed [DATA_W-1:0] v, input logic is_last);
    int gap;
    in_req   <= '{value: v, last_in: is_last};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else if (gap_max > 0) begin
      gap = $urandom_range(gap_max, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(15, 0);
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value(input value_mix_t mix);
    logic signed [DATA_W-1:0] v;
    case (mix)
      MIX_NARROW: v = $signed($urandom_range(6, 0)) - 3;
      MIX_EDGE: begin
        case ($urandom_range(5, 0))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = VAL_MIN + 1;
          3: v = VAL_MAX - 1;
          4: v = -1;
          default: v = 0;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_run(input int len, input value_mix_t mix);
    for (int i = 0; i < len; i++) begin
      send_item(pick_value(mix), i == len - 1);
    end
  endtask

  // Let the block drain everything owed before going on.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sorted_expect.size() != 0) @(posedge clk);
  endtask

  // Extreme values in mixed order, and a run of one value.
  task automatic test_extremes();
    send_item(VAL_MAX, 1'b0);
    send_item(VAL_MIN, 1'b0);
    send_item(0, 1'b0);
    send_item(-1, 1'b0);
    send_item(1, 1'b0);
    send_item(VAL_MIN + 1, 1'b0);
    send_item(VAL_MAX - 1, 1'b1);
    send_item(-12345, 1'b1);
    wait_drained();
  endtask

  // Already sorted, reversed, and repeated keys.
  task automatic test_ordering();
    for (int i = 0; i < 5; i++) send_item(i * 7 - 10, i == 4);
    for (int i = 0; i < 5; i++) send_item(100 - i * 33, i == 4);
    send_item(5, 1'b0);
    send_item(-2, 1'b0);
    send_item(5, 1'b0);
    send_item(-2, 1'b1);
    wait_drained();
  endtask

  // Exactly full, last value dropped, and several dropped before the last.
  task automatic test_capacity();
    send_run(MAX_ITEMS, MIX_FULL);
    send_run(MAX_ITEMS + 1, MIX_NARROW);
    send_run(MAX_ITEMS + 5, MIX_FULL);
    wait_drained();
  endtask

  // Hold the output for a long time while the sender keeps offering requests.
  task automatic test_backpressure();
    gap_max   = 0;
    stall_max = 0;
    hold_output = 1'b1;
    send_run(12, MIX_FULL);
    send_run(MAX_ITEMS, MIX_FULL);
    send_run(6, MIX_EDGE);
    wait_drained();
  endtask

  // Runs of random length and content under changing idle patterns.
  task automatic test_random();
    int start;
    int len;
    value_mix_t mix;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      case ($urandom_range(3, 0))
        0: gap_max = 0;
        1: gap_max = 2;
        default: gap_max = 6;
      endcase
      case ($urandom_range(3, 0))
        0: stall_max = 0;
        1: stall_max = 2;
        default: stall_max = 6;
      endcase
      case ($urandom_range(9, 0))
        0: len = 1;
        1: len = $urandom_range(MAX_ITEMS + 4, MAX_ITEMS - 1);
        default: len = $urandom_range(12, 2);
      endcase
      case ($urandom_range(5, 0))
        0: mix = MIX_NARROW;
        1: mix = MIX_EDGE;
        default: mix = MIX_FULL;
      endcase
      send_run(len, mix);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_max   = 0;
    stall_max = 0;
    test_extremes();
    gap_max   = 3;
    stall_max = 3;
    test_ordering();
    test_capacity();
    test_backpressure();
    test_random();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
